// ===== sv/rau_pkg.sv =====
// Package for the rational arithmetic unit: widths, operation codes,
// controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
  localparam int OPW = 16;
  localparam int MW = 2 * OPW + 1;
  localparam int NUMW = 33;
  localparam int DENW = 31;
  localparam int CW = $clog2(MW + 1);

  localparam logic [1:0] DSEL_ADEN = 2'd0;
  localparam logic [1:0] DSEL_BDEN = 2'd1;
  localparam logic [1:0] DSEL_NUM = 2'd2;
  localparam logic [1:0] DSEL_DEN = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_DIV = 2'd2,
    OP_BAD = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_G1, S_DIVA, S_DIVB, S_FORM, S_GINIT, S_G2, S_RED_N,
    S_RED_D, S_DONE, S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic gcd_init_den;
    logic gcd_init_res;
    logic gcd_step;
    logic div_start;
    logic [1:0] div_sel;
    logic div_step;
    logic form;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic num_zero;
    logic gcd_done;
    logic div_done;
    logic is_add;
  } sts_t;
endpackage
`default_nettype wire

// ===== sv/rau_if.sv =====
// Valid/ready channel interfaces for the rational arithmetic unit.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rau_in_if;
  import rau_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic signed [OPW-1:0] a_num;
  logic signed [OPW-1:0] a_den;
  logic signed [OPW-1:0] b_num;
  logic signed [OPW-1:0] b_den;
  modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  import rau_pkg::*;
  logic valid;
  logic ready;
  logic signed [NUMW-1:0] res_num;
  logic [DENW-1:0] res_den;
  logic status;
  modport source (output valid, res_num, res_den, status, input ready);
  modport sink (input valid, res_num, res_den, status, output ready);
endinterface
`default_nettype wire

// ===== sv/rau_ctrl.sv =====
// Controller for the rational arithmetic unit: sequences GCD and
// division steps in the datapath. Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rau_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output rau_pkg::cmd_t     cmd_o,
  input  wire rau_pkg::sts_t sts_i
);
  import rau_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_LOAD;
      S_LOAD: begin
        if (sts_i.err) state_d = S_DONE;
        else if (sts_i.is_add) state_d = S_G1;
        else state_d = S_FORM;
      end
      S_G1: if (sts_i.gcd_done) state_d = S_DIVA;
      S_DIVA: if (sts_i.div_done) state_d = S_DIVB;
      S_DIVB: if (sts_i.div_done) state_d = S_FORM;
      S_FORM: state_d = S_GINIT;
      S_GINIT: state_d = S_G2;
      S_G2: begin
        if (sts_i.num_zero) state_d = S_DONE;
        else if (sts_i.gcd_done) state_d = S_RED_N;
      end
      S_RED_N: if (sts_i.div_done) state_d = S_RED_D;
      S_RED_D: if (sts_i.div_done) state_d = S_DONE;
      S_DONE: state_d = S_OUT;
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_LOAD: cmd_o.gcd_init_den = sts_i.is_add & ~sts_i.err;
      S_G1: begin
        cmd_o.gcd_step = 1'b1;
        cmd_o.div_start = sts_i.gcd_done;
        cmd_o.div_sel = DSEL_ADEN;
      end
      S_DIVA: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_start = sts_i.div_done;
        cmd_o.div_sel = DSEL_BDEN;
      end
      S_DIVB: cmd_o.div_step = 1'b1;
      S_FORM: cmd_o.form = 1'b1;
      S_GINIT: cmd_o.gcd_init_res = 1'b1;
      S_G2: begin
        cmd_o.gcd_step = ~sts_i.num_zero;
        cmd_o.div_start = sts_i.gcd_done & ~sts_i.num_zero;
        cmd_o.div_sel = DSEL_NUM;
      end
      S_RED_N: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_start = sts_i.div_done;
        cmd_o.div_sel = DSEL_DEN;
      end
      S_RED_D: cmd_o.div_step = 1'b1;
      S_DONE: cmd_o.finish = 1'b1;
      S_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/rau_dp.sv =====
// Datapath for the rational arithmetic unit: operand registers, a shared
// GCD (one remainder per step via the divider) and a restoring divider.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rau_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire rau_pkg::cmd_t          cmd_i,
  output rau_pkg::sts_t               sts_o,
  input  wire logic [1:0]             operation_i,
  input  wire logic [rau_pkg::OPW-1:0] a_num_i,
  input  wire logic [rau_pkg::OPW-1:0] a_den_i,
  input  wire logic [rau_pkg::OPW-1:0] b_num_i,
  input  wire logic [rau_pkg::OPW-1:0] b_den_i,
  output logic [rau_pkg::NUMW-1:0]    res_num_o,
  output logic [rau_pkg::DENW-1:0]    res_den_o,
  output logic                        status_o
);
  import rau_pkg::*;

  op_e op_q;
  logic [OPW:0] anm_q, adm_q, bnm_q, bdm_q;
  logic sa_q, sb_q;
  logic [MW-1:0] num_q, num_d, den_q;
  logic neg_q, neg_d;
  logic [MW-1:0] gu_q, gv_q;
  logic [MW-1:0] qa_q, qb_q;
  // divider
  logic [MW-1:0] dvd_q, dvs_q, quo_q, rem_q;
  logic [CW-1:0] cnt_q;
  logic busy_q;
  logic [1:0] dsel_q;
  logic gcd_mode_q;
  logic [MW:0] trial;
  logic [MW-1:0] rem_sh;
  logic ph_q;
  logic [NUMW-1:0] rn_q;
  logic [DENW-1:0] rd_q;
  logic st_q;

  function automatic logic [OPW:0] mag(input logic [OPW-1:0] v);
    return v[OPW-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
  endfunction

  function automatic logic [MW-1:0] mulw(input logic [OPW:0] x, input logic [OPW:0] y);
    logic [2*OPW+1:0] p;
    p = {{(OPW+1){1'b0}}, x} * {{(OPW+1){1'b0}}, y};
    return p[MW-1:0];
  endfunction

  logic err;
  assign err = (adm_q == '0) || (bdm_q == '0) || (op_q == OP_BAD) ||
               ((op_q == OP_DIV) && (bnm_q == '0));
  assign sts_o.err = err;
  assign sts_o.is_add = (op_q == OP_ADD);
  assign sts_o.num_zero = (num_q == '0);
  assign sts_o.gcd_done = (gv_q == '0) && !busy_q && !ph_q;
  assign sts_o.div_done = !busy_q && !gcd_mode_q;

  assign rem_sh = {rem_q[MW-2:0], dvd_q[MW-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, dvs_q};

  // product and sum or difference forming for the result
  logic [MW-1:0] p1, p2;
  always_comb begin
    if (op_q == OP_ADD) begin
      p1 = mulw(anm_q, qb_q[OPW:0]);
      p2 = mulw(bnm_q, qa_q[OPW:0]);
    end else if (op_q == OP_MUL) begin
      p1 = mulw(anm_q, bnm_q);
      p2 = mulw(adm_q, bdm_q);
    end else begin
      p1 = mulw(anm_q, bdm_q);
      p2 = mulw(adm_q, bnm_q);
    end
    neg_d = sa_q ^ sb_q;
    num_d = p1;
    if (op_q == OP_ADD) begin
      if (sa_q == sb_q) begin
        num_d = p1 + p2; neg_d = sa_q;
      end else if (p1 >= p2) begin
        num_d = p1 - p2; neg_d = sa_q;
      end else begin
        num_d = p2 - p1; neg_d = sb_q;
      end
    end
  end

  logic [MW-1:0] den_add;
  assign den_add = mulw(qa_q[OPW:0], bdm_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      gcd_mode_q <= 1'b0;
      ph_q <= 1'b0;
    end else begin
      if (cmd_i.gcd_init_den || cmd_i.gcd_init_res) begin
        gcd_mode_q <= 1'b1;
        ph_q <= 1'b0;
      end else if (cmd_i.gcd_step && gcd_mode_q && !busy_q && !ph_q && gv_q != '0) begin
        busy_q <= 1'b1;
        ph_q <= 1'b1;
      end else if (cmd_i.div_start) begin
        busy_q <= 1'b1;
        gcd_mode_q <= 1'b0;
      end else if (busy_q && cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end else if (ph_q && !busy_q) begin
        ph_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_e'(operation_i);
      anm_q <= mag(a_num_i); adm_q <= mag(a_den_i);
      bnm_q <= mag(b_num_i); bdm_q <= mag(b_den_i);
      sa_q <= a_num_i[OPW-1] ^ a_den_i[OPW-1];
      sb_q <= b_num_i[OPW-1] ^ b_den_i[OPW-1];
    end
    if (cmd_i.gcd_init_den) begin
      gu_q <= MW'(adm_q); gv_q <= MW'(bdm_q);
    end
    if (cmd_i.gcd_init_res) begin
      gu_q <= num_q; gv_q <= den_q;
    end
    if (cmd_i.form) begin
      num_q <= num_d;
      neg_q <= neg_d;
      den_q <= (op_q == OP_ADD) ? den_add : p2;
    end
    if (cmd_i.gcd_step && gcd_mode_q && !busy_q && !ph_q && gv_q != '0) begin
      dvd_q <= gu_q; dvs_q <= gv_q; rem_q <= '0; cnt_q <= CW'(MW);
    end else if (cmd_i.div_start) begin
      dsel_q <= cmd_i.div_sel;
      unique case (cmd_i.div_sel)
        DSEL_ADEN: dvd_q <= MW'(adm_q);
        DSEL_BDEN: dvd_q <= MW'(bdm_q);
        DSEL_NUM: dvd_q <= num_q;
        default: dvd_q <= den_q;
      endcase
      dvs_q <= gu_q;
      rem_q <= '0;
      cnt_q <= CW'(MW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      dvd_q <= {dvd_q[MW-2:0], 1'b0};
      if (!trial[MW]) begin
        rem_q <= trial[MW-1:0];
        quo_q <= {quo_q[MW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[MW-2:0], 1'b0};
      end
    end else if (ph_q) begin
      gu_q <= gv_q; gv_q <= rem_q;
    end
    if (!busy_q && !gcd_mode_q && cnt_q == '0) begin
      unique case (dsel_q)
        DSEL_ADEN: qa_q <= quo_q;
        DSEL_BDEN: qb_q <= quo_q;
        DSEL_NUM: num_q <= quo_q;
        default: den_q <= quo_q;
      endcase
      if (!cmd_i.div_start) cnt_q <= CW'(MW + 1);
    end
    if (cmd_i.load) cnt_q <= CW'(MW + 1);
    if (cmd_i.finish) begin
      if (err) begin
        rn_q <= '0; rd_q <= '0; st_q <= 1'b1;
      end else if (num_q == '0) begin
        rn_q <= '0; rd_q <= DENW'(1); st_q <= 1'b0;
      end else begin
        rn_q <= neg_q ? NUMW'(-num_q) : NUMW'(num_q);
        rd_q <= DENW'(den_q); st_q <= 1'b0;
      end
    end
  end

  assign res_num_o = rn_q;
  assign res_den_o = rd_q;
  assign status_o = st_q;
endmodule
`default_nettype wire

// ===== sv/rational_arithmetic_unit.sv =====
// Rational arithmetic unit top level: controller plus datapath.
// Depends on rau_pkg, rau_if, rau_ctrl and rau_dp.
//
// Usage: the in channel carries one item (operation, two fractions); the
// out channel returns one reduced fraction and a status bit per item.
// One item is processed at a time through a shared restoring divider;
// each Euclid remainder is one pass through it. Multiply and divide
// form the products, then reduce them by a GCD (k remainders) and two
// exact divisions. Add first runs a GCD of the denominators (j
// remainders) and two exact divisions before doing the same. An error
// item skips all computation and a zero numerator skips the reduction.
// The next item is taken in the cycle after the result is accepted.
// Reset returns the controller to idle with in.ready high and no result
// pending. When the receiver stalls the result holds in the output
// register and no new item is taken until it is delivered.
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit (
  input wire logic clk_i,
  input wire logic rst_ni,
  rau_in_if.sink   in_i,
  rau_out_if.source out_o
);
  import rau_pkg::*;
  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .cmd_o(cmd), .sts_i(sts)
  );

  rau_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .operation_i(in_i.operation), .a_num_i(in_i.a_num), .a_den_i(in_i.a_den),
    .b_num_i(in_i.b_num), .b_den_i(in_i.b_den),
    .res_num_o(out_o.res_num), .res_den_o(out_o.res_den),
    .status_o(out_o.status)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid)) else $error("ready while result pending");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status) |-> (out_o.res_den == '0 && out_o.res_num == '0))
    else $error("error result not cleared");
  a_ok_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.status) |-> (out_o.res_den != '0))
    else $error("zero denominator on valid result");
endmodule
`default_nettype wire
